FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the tape loop machine sources
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, disabled while reset is asserted (active-low reset)
`define ASSERT_CLK_RSTN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RSTN(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

FILE: src/tlms_pkg.sv
// ----------------------------------------------------------------------------
// tlms_pkg
// Sizes, opcodes and status codes of the tape loop machine step unit
// ----------------------------------------------------------------------------
package tlms_pkg;

    // storage sizes
    localparam int TAPE_DEPTH    = 4096;
    localparam int STACK_DEPTH   = 64;
    localparam int ADDRESS_WIDTH = 16;

    localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);

    // port field widths
    localparam int OPCODE_W = 4;
    localparam int VALUE_W  = 16;
    localparam int NEXT_W   = 16;
    localparam int CELL_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(255);

    // command opcodes
    localparam logic [OPCODE_W-1:0] OP_PTR_INC    = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_PTR_DEC    = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_CELL_INC   = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_CELL_DEC   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_OUT        = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_IN         = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_LOOP_OPEN  = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_LOOP_CLOSE = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_NOP        = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_END        = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PTR_BELOW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PTR_PAST    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STACK_EMPTY = 3'd4;

endpackage

FILE: src/tape_loop_machine_step.sv
// ----------------------------------------------------------------------------
// tape_loop_machine_step
// Execution unit for the ten-opcode tape language, one command per beat
// ----------------------------------------------------------------------------
// Each command is handled in an accept step and an execute step: in the accept
// cycle the current tape cell and the top of the loop stack are read from their
// synchronous RAMs, and once the result register is free the command executes,
// writes the cell or stack entry back and loads the result register. A new
// command is not taken until the previous one has executed. A finished result may wait in
// the output register while the next command is already accepted and read.
// After reset a clearing pass writes zero to every tape cell, one per cycle,
// with s_ready held low.
`include "assert_macros.svh"

module tape_loop_machine_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tlms_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic signed [tlms_pkg::VALUE_W-1:0] s_input_value,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tlms_pkg::NEXT_W-1:0]     m_next_address,
    output logic                            m_out_valid,
    output logic [tlms_pkg::CELL_W-1:0]     m_out_byte,
    output logic                            m_halted,
    output logic [tlms_pkg::STATUS_W-1:0]   m_status
);

    import tlms_pkg::*;

    // architectural state
    logic [TAPE_AW-1:0]       dp_reg, dp_next;
    logic [ADDRESS_WIDTH-1:0] pa_reg, pa_next;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic                     stopped_reg, stopped_next;

    // tape clearing pass
    logic                     clear_reg;
    logic [TAPE_AW-1:0]       clear_idx_reg;

    // execute stage
    logic                     exec_valid_reg;
    logic [OPCODE_W-1:0]      op_reg;
    logic signed [VALUE_W-1:0] value_reg;

    // result register
    logic                     m_valid_reg;
    logic [NEXT_W-1:0]        m_next_address_reg;
    logic                     m_out_valid_reg;
    logic [CELL_W-1:0]        m_out_byte_reg;
    logic                     m_halted_reg;
    logic [STATUS_W-1:0]      m_status_reg;

    // ram ports
    logic                     tape_we, exec_tape_we;
    logic [TAPE_AW-1:0]       tape_waddr;
    logic [CELL_W-1:0]        tape_wdata, exec_tape_wdata;
    logic [CELL_W-1:0]        cell_rd;
    logic                     stack_we;
    logic [ADDRESS_WIDTH-1:0] stack_wdata;
    logic [ADDRESS_WIDTH-1:0] stack_top;

    // execute results
    logic                     res_out_valid;
    logic [CELL_W-1:0]        res_out_byte;
    logic [STATUS_W-1:0]      res_status;
    logic [CELL_W-1:0]        sat_value;
    logic [ADDRESS_WIDTH-1:0] pa_inc;

    logic                     s_fire, exec_fire;

    // handshakes
    assign s_ready   = !exec_valid_reg && !clear_reg;
    assign s_fire    = s_valid && s_ready;
    assign exec_fire = exec_valid_reg && (!m_valid_reg || m_ready);

    // tape memory, cleared port shared with execute write-back
    assign tape_we    = clear_reg || (exec_fire && exec_tape_we);
    assign tape_waddr = clear_reg ? clear_idx_reg : dp_reg;
    assign tape_wdata = clear_reg ? '0 : exec_tape_wdata;

    tlms_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk     (aclk),
        .wr_en   (tape_we),
        .wr_addr (tape_waddr),
        .wr_data (tape_wdata),
        .rd_en   (s_fire),
        .rd_addr (dp_reg),
        .rd_data (cell_rd)
    );

    // loop stack memory, top entry read at accept time
    tlms_ram #(
        .WIDTH (ADDRESS_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (aclk),
        .wr_en   (exec_fire && stack_we),
        .wr_addr (depth_reg[STACK_AW-1:0]),
        .wr_data (stack_wdata),
        .rd_en   (s_fire),
        .rd_addr (STACK_AW'(depth_reg - DEPTH_W'(1))),
        .rd_data (stack_top)
    );

    // input value saturated to the cell range
    always_comb begin
        if (value_reg[VALUE_W-1]) begin
            sat_value = '0;
        end else if (value_reg > $signed({{(VALUE_W-CELL_W){1'b0}}, CELL_MAX})) begin
            sat_value = CELL_MAX;
        end else begin
            sat_value = value_reg[CELL_W-1:0];
        end
    end

    assign pa_inc = pa_reg + ADDRESS_WIDTH'(1);

    // command execute
    always_comb begin
        dp_next         = dp_reg;
        pa_next         = pa_reg;
        depth_next      = depth_reg;
        stopped_next    = stopped_reg;
        exec_tape_we    = 1'b0;
        exec_tape_wdata = cell_rd;
        stack_we        = 1'b0;
        stack_wdata     = pa_inc;
        res_out_valid   = 1'b0;
        res_out_byte    = '0;
        res_status      = ST_OK;
        if (!stopped_reg) begin
            unique case (op_reg)
                OP_PTR_INC: begin
                    if (dp_reg == TAPE_AW'(TAPE_DEPTH - 1)) begin
                        res_status = ST_PTR_PAST;
                    end else begin
                        dp_next = dp_reg + TAPE_AW'(1);
                        pa_next = pa_inc;
                    end
                end
                OP_PTR_DEC: begin
                    if (dp_reg == '0) begin
                        res_status = ST_PTR_BELOW;
                    end else begin
                        dp_next = dp_reg - TAPE_AW'(1);
                        pa_next = pa_inc;
                    end
                end
                OP_CELL_INC: begin
                    exec_tape_we    = 1'b1;
                    exec_tape_wdata = cell_rd + CELL_W'(1);
                    pa_next         = pa_inc;
                end
                OP_CELL_DEC: begin
                    exec_tape_we    = 1'b1;
                    exec_tape_wdata = cell_rd - CELL_W'(1);
                    pa_next         = pa_inc;
                end
                OP_OUT: begin
                    res_out_valid = 1'b1;
                    res_out_byte  = cell_rd;
                    pa_next       = pa_inc;
                end
                OP_IN: begin
                    exec_tape_we    = 1'b1;
                    exec_tape_wdata = sat_value;
                    pa_next         = pa_inc;
                end
                OP_LOOP_OPEN: begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                        res_status = ST_STACK_FULL;
                    end else begin
                        stack_we   = 1'b1;
                        pa_next    = pa_inc;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                end
                OP_LOOP_CLOSE: begin
                    if (depth_reg == '0) begin
                        res_status = ST_STACK_EMPTY;
                    end else if (cell_rd != '0) begin
                        pa_next = stack_top;
                    end else begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        pa_next    = pa_inc;
                    end
                end
                OP_END: begin
                    stopped_next = 1'b1;
                end
                // nop and unused codes just advance
                default: begin
                    pa_next = pa_inc;
                end
            endcase
        end
    end

    // control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_reg         <= '0;
            pa_reg         <= '0;
            depth_reg      <= '0;
            stopped_reg    <= 1'b0;
            clear_reg      <= 1'b1;
            clear_idx_reg  <= '0;
            exec_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clear_reg) begin
                clear_idx_reg <= clear_idx_reg + TAPE_AW'(1);
                if (clear_idx_reg == TAPE_AW'(TAPE_DEPTH - 1)) begin
                    clear_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                exec_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                exec_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                dp_reg      <= dp_next;
                pa_reg      <= pa_next;
                depth_reg   <= depth_next;
                stopped_reg <= stopped_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // command capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= s_opcode;
            value_reg <= s_input_value;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_next_address_reg <= NEXT_W'(pa_next);
            m_out_valid_reg    <= res_out_valid;
            m_out_byte_reg     <= res_out_byte;
            m_halted_reg       <= stopped_next;
            m_status_reg       <= res_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_address = m_next_address_reg;
    assign m_out_valid    = m_out_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_halted       = m_halted_reg;
    assign m_status       = m_status_reg;

    // checks
    `ASSERT_CLK_RSTN(a_no_accept_in_clear, aclk, aresetn, clear_reg |-> !s_ready, "beat accepted during tape clear")
    `ASSERT_CLK_RSTN(a_accept_to_exec, aclk, aresetn, s_fire |=> (exec_valid_reg && !s_ready), "accepted beat did not reach execute")
    `ASSERT_CLK_RSTN(a_depth_bound, aclk, aresetn, depth_reg <= DEPTH_W'(STACK_DEPTH), "loop stack depth overflow")
    `ASSERT_CLK_RSTN(a_halt_sticks, aclk, aresetn, stopped_reg |=> stopped_reg, "halt flag dropped")
    `ASSERT_CLK_RSTN(a_out_ok, aclk, aresetn, (m_valid && m_out_valid) |-> (m_status == ST_OK && !m_halted), "output byte with fault or halt")

endmodule

FILE: src/tlms_ram.sv
// ----------------------------------------------------------------------------
// tlms_ram
// Simple dual-port RAM: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tlms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while rd_en is low
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: tb/tape_loop_machine_step_tb.sv
// ----------------------------------------------------------------------------
// tape_loop_machine_step_tb
// Self-checking bench for the tape loop machine step unit: commands are
// driven from a queue, each accepted command is executed on a local copy of
// the tape, pointer, address and loop stack, and every result beat is
// compared field by field. The run covers directed edge cases, a short
// pointer walk below zero, a stack fill and drain, counted loops and random
// noise under four idling profiles, then a halt and commands it must ignore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_loop_machine_step_tb;
    import tlms_pkg::*;

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MIX_ITEMS     = 330;

    localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = OP_END + 1'b1;
    localparam logic [OPCODE_W-1:0] OP_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [VALUE_W-1:0]  value;
    } command_t;

    typedef struct packed {
        logic [NEXT_W-1:0]   next_address;
        logic                out_valid;
        logic [CELL_W-1:0]   out_byte;
        logic                halted;
        logic [STATUS_W-1:0] status;
    } step_result_t;

    // clock, reset and block ports
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OPCODE_W-1:0] s_opcode = '0;
    logic signed [VALUE_W-1:0] s_input_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [NEXT_W-1:0] m_next_address;
    logic m_out_valid;
    logic [CELL_W-1:0] m_out_byte;
    logic m_halted;
    logic [STATUS_W-1:0] m_status;

    always #5 aclk = ~aclk;

    tape_loop_machine_step dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_input_value  (s_input_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_address (m_next_address),
        .m_out_valid    (m_out_valid),
        .m_out_byte     (m_out_byte),
        .m_halted       (m_halted),
        .m_status       (m_status)
    );

    // queues and counters
    command_t     pending_cmds[$];
    step_result_t expected_results[$];
    command_t     drv_cmd;
    step_result_t mon_want;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;
    int cmds_accepted   = 0;
    int results_checked = 0;
    int built_items     = 0;
    int loop_jumps      = 0;
    int out_beats       = 0;
    int status_seen[5];
    int idle_cycles     = 0;

    // machine state as the bench sees it
    logic [CELL_W-1:0]  tape_m [TAPE_DEPTH];
    logic [TAPE_AW-1:0] ptr_m = '0;
    logic [NEXT_W-1:0]  pc_m = '0;
    logic [NEXT_W-1:0]  returns_m [STACK_DEPTH];
    int                 depth_m = 0;
    logic               stopped_m = 1'b0;

    initial begin
        for (int i = 0; i < TAPE_DEPTH; i++) tape_m[i] = '0;
        for (int i = 0; i < 5; i++) status_seen[i] = 0;
    end

    // executes one command on the local state, returns its result beat
    function automatic step_result_t execute_command(command_t c);
        step_result_t r;
        logic [CELL_W-1:0] cur;
        int v;
        r = '0;
        if (stopped_m) begin
            r.next_address = pc_m;
            r.halted = 1'b1;
            return r;
        end
        cur = tape_m[ptr_m];
        r.status = ST_OK;
        case (c.opcode)
            OP_PTR_INC: begin
                if (ptr_m == TAPE_AW'(TAPE_DEPTH - 1)) r.status = ST_PTR_PAST;
                else begin
                    ptr_m++;
                    pc_m++;
                end
            end
            OP_PTR_DEC: begin
                if (ptr_m == '0) r.status = ST_PTR_BELOW;
                else begin
                    ptr_m--;
                    pc_m++;
                end
            end
            OP_CELL_INC: begin
                tape_m[ptr_m] = cur + 1'b1;
                pc_m++;
            end
            OP_CELL_DEC: begin
                tape_m[ptr_m] = cur - 1'b1;
                pc_m++;
            end
            OP_OUT: begin
                pc_m++;
                r.out_valid = 1'b1;
                r.out_byte = cur;
                out_beats++;
            end
            OP_IN: begin
                // saturate the signed value into a byte
                v = $signed(c.value);
                if (v > int'(CELL_MAX)) v = int'(CELL_MAX);
                if (v < 0) v = 0;
                tape_m[ptr_m] = CELL_W'(v);
                pc_m++;
            end
            OP_LOOP_OPEN: begin
                if (depth_m >= STACK_DEPTH) r.status = ST_STACK_FULL;
                else begin
                    pc_m++;
                    returns_m[depth_m] = pc_m;
                    depth_m++;
                end
            end
            OP_LOOP_CLOSE: begin
                if (depth_m == 0) r.status = ST_STACK_EMPTY;
                else if (cur != '0) begin
                    pc_m = returns_m[depth_m - 1];
                    loop_jumps++;
                end else begin
                    depth_m--;
                    pc_m++;
                end
            end
            OP_END: stopped_m = 1'b1;
            default: pc_m++;
        endcase
        r.next_address = pc_m;
        r.halted = stopped_m;
        status_seen[r.status]++;
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, field, got, want);
    endtask

    // stimulus helpers
    task automatic add_cmd(input logic [OPCODE_W-1:0] op, input int val);
        command_t c;
        c.opcode = op;
        c.value = VALUE_W'(val);
        pending_cmds.insert(pending_cmds.size(), c);
        built_items++;
    endtask

    function automatic int rand_value();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: return $urandom_range(0, 65535);
            1: return int'($urandom_range(0, 300)) - 20;
            2: return $urandom_range(0, 255);
            default: begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return 32767;
                    2: return -1;
                    3: return 0;
                    4: return 255;
                    default: return 256;
                endcase
            end
        endcase
    endfunction

    // any command but end, roughly balanced pointer moves
    function automatic logic [OPCODE_W-1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return OP_PTR_INC;
        if (r < 24) return OP_PTR_DEC;
        if (r < 38) return OP_CELL_INC;
        if (r < 50) return OP_CELL_DEC;
        if (r < 60) return OP_OUT;
        if (r < 70) return OP_IN;
        if (r < 78) return OP_LOOP_OPEN;
        if (r < 88) return OP_LOOP_CLOSE;
        if (r < 94) return OP_NOP;
        return OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    endfunction

    // counted loop as the program would run it: load trip count, open,
    // then body and close once per trip, last close pops
    task automatic add_count_loop(input int trips, input int nest);
        int extra;
        add_cmd(OP_IN, trips);
        add_cmd(OP_LOOP_OPEN, rand_value());
        for (int i = 0; i < trips; i++) begin
            add_cmd(OP_CELL_DEC, rand_value());
            if (nest > 0 && $urandom_range(0, 1) == 1) begin
                add_cmd(OP_PTR_INC, rand_value());
                add_count_loop($urandom_range(1, 3), nest - 1);
                add_cmd(OP_PTR_DEC, rand_value());
            end
            extra = $urandom_range(0, 2);
            for (int j = 0; j < extra; j++) begin
                case ($urandom_range(0, 2))
                    0: add_cmd(OP_OUT, rand_value());
                    1: add_cmd(OP_NOP, rand_value());
                    default: add_cmd(OPCODE_W'($urandom_range(OP_FIRST_UNUSED,
                                                              OP_LAST_UNUSED)),
                                     rand_value());
                endcase
            end
            add_cmd(OP_LOOP_CLOSE, rand_value());
        end
    endtask

    // mostly well-formed loops, the rest random noise
    task automatic add_random_mix(input int n);
        int stop_at;
        int burst;
        stop_at = built_items + n;
        while (built_items < stop_at) begin
            if ($urandom_range(0, 99) < 60) begin
                add_count_loop($urandom_range(1, 4), $urandom_range(0, 2));
            end else begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++) add_cmd(rand_op(), rand_value());
            end
        end
    endtask

    // hold the sender until every queued beat is out and answered
    task automatic drain();
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                drv_cmd.opcode = s_opcode;
                drv_cmd.value = s_input_value;
                expected_results.insert(expected_results.size(), execute_command(drv_cmd));
                cmds_accepted++;
            end
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                drv_cmd = pending_cmds.pop_front();
                s_valid <= 1'b1;
                s_opcode <= drv_cmd.opcode;
                s_input_value <= drv_cmd.value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("beat with nothing expected", 1, 0);
            end else begin
                mon_want = expected_results.pop_front();
                if (m_next_address !== mon_want.next_address)
                    report_mismatch("next_address", m_next_address, mon_want.next_address);
                if (m_out_valid !== mon_want.out_valid)
                    report_mismatch("out_valid", m_out_valid, mon_want.out_valid);
                if (m_out_byte !== mon_want.out_byte)
                    report_mismatch("out_byte", m_out_byte, mon_want.out_byte);
                if (m_halted !== mon_want.halted)
                    report_mismatch("halted", m_halted, mon_want.halted);
                if (m_status !== mon_want.status)
                    report_mismatch("status", m_status, mon_want.status);
            end
            results_checked++;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a beat", idle_cycles);
                $display("tape_loop_machine_step regression: fail");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
            endcase

            if (phase == 0) begin
                // directed edge cases on a fresh machine
                add_cmd(OP_LOOP_CLOSE, 0);       // empty stack, zero cell
                add_cmd(OP_PTR_DEC, 0);          // pointer below zero
                add_cmd(OP_IN, 32767);           // saturates high
                add_cmd(OP_OUT, -32768);
                add_cmd(OP_CELL_INC, 0);         // wraps to zero
                add_cmd(OP_OUT, 0);
                add_cmd(OP_CELL_DEC, 0);         // wraps to 255
                add_cmd(OP_LOOP_CLOSE, 0);       // empty stack, nonzero cell
                add_cmd(OP_IN, -32768);          // saturates low
                add_cmd(OP_IN, -1);
                add_cmd(OP_IN, 256);
                add_cmd(OP_IN, 255);
                add_cmd(OP_IN, 0);
                add_cmd(OP_CELL_DEC, 0);
                add_cmd(OP_IN, 1);
                add_cmd(OP_LOOP_OPEN, 0);
                add_cmd(OP_OUT, 0);
                add_cmd(OP_LOOP_CLOSE, 0);       // nonzero cell, jumps back
                add_cmd(OP_CELL_DEC, 0);
                add_cmd(OP_LOOP_CLOSE, 0);       // zero cell, pops
                add_cmd(OP_PTR_INC, 0);
                add_cmd(OP_OUT, 0);
                add_cmd(OP_PTR_DEC, 0);
                add_cmd(OP_NOP, 32767);
                add_cmd(OP_LAST_UNUSED, -1);

                // short pointer walk up, then back down past zero
                for (int i = 0; i < 16; i++) add_cmd(OP_PTR_INC, rand_value());
                for (int i = 0; i < 20; i++) add_cmd(OP_PTR_DEC, rand_value());
            end

            if (phase == 1) begin
                // stack fill past full, then drain past empty
                for (int i = 0; i < STACK_DEPTH + 2; i++) add_cmd(OP_LOOP_OPEN, rand_value());
                add_cmd(OP_IN, 0);
                for (int i = 0; i < STACK_DEPTH + 2; i++) add_cmd(OP_LOOP_CLOSE, rand_value());
            end

            add_random_mix(MIX_ITEMS);
            drain();
        end

        // halt, then commands that must be ignored
        sender_idle_pct = 21;
        recv_stall_pct = 21;
        add_cmd(OP_END, rand_value());
        for (int i = 0; i < 8; i++) add_cmd(rand_op(), rand_value());
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("ran %0d commands, checked %0d results, %0d out beats, %0d loop jumps",
                 cmds_accepted, results_checked, out_beats, loop_jumps);
        $display("faults: below zero %0d, past tape %0d, stack full %0d, stack empty %0d",
                 status_seen[ST_PTR_BELOW], status_seen[ST_PTR_PAST],
                 status_seen[ST_STACK_FULL], status_seen[ST_STACK_EMPTY]);
        if (mismatch_count == 0) begin
            $display("tape_loop_machine_step regression: pass");
        end else begin
            $display("tape_loop_machine_step regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/tlms_pkg.sv
src/tlms_ram.sv
src/tape_loop_machine_step.sv
tb/tape_loop_machine_step_tb.sv
